/* rtl/core/pll_spread_spectrum_settings_unit_assert.svh */
// Assertion macros for the spread-spectrum settings unit.
// Each use names clk and arst_n of the module that it stands in.
`ifndef PLL_SPREAD_SPECTRUM_SETTINGS_UNIT_ASSERT_SVH
`define PLL_SPREAD_SPECTRUM_SETTINGS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSSU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/pssu_pkg.sv */
package pssu_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_FREF,
		ST_DIV_FM,
		ST_DIV_DIV,
		ST_NORM,
		ST_DIV_PCT,
		ST_DIV_STEP,
		ST_DONE
	} pssu_state_t;

	typedef enum logic [1:0] {
		CFG_REF_CLOCK = 2'd0,
		CFG_SPREAD    = 2'd1
	} pssu_cfg_idx_t;

	localparam logic [31:0] REF_CLOCK_RST  = 32'd24000000;
	localparam logic [3:0]  SPREAD_RST     = 4'd5;
	localparam logic [31:0] MIN_FREF       = 32'd70;
	localparam logic [31:0] PCT_SCALE      = 32'd100;
	localparam logic [31:0] MANT_MAX       = 32'd127;
	localparam logic [2:0]  EXP_MAX        = 3'd7;
	localparam logic [19:0] STEP_MAX       = 20'hFFFFF;
	localparam logic [3:0]  MODE_FIELD_SET = 4'b0001;
	localparam int          STEP_SHIFT     = 18;
	localparam int          DIV_BITS       = 32;

endpackage

/* rtl/core/pll_spread_spectrum_settings_unit.sv */
// Five 32-bit divisions share one radix-2 restoring divider under a small sequencer,
// with a normalization step of at most 7 shifts; when the divided reference is below
// 70 the sequence ends after the first division. A new item is accepted only once the
// previous result has been loaded into the output register.
// Reset: arst_n clears the sequencer and output valid, and loads the reference clock
// (24000000 Hz) and spread percentage (5) registers with their defaults.
`include "pll_spread_spectrum_settings_unit_assert.svh"

module pll_spread_spectrum_settings_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // [9:0] multiplier_m, [16:10] predivider_n,
	                               // [48:17] mode_word, [55:49] zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [19:0] delta_step, [22:20] mod_exponent,
	                               // [29:23] mod_mantissa, [61:30] new_mode_word,
	                               // [63:62] zero
	output logic        m_tuser    // [0] ref_too_low
);

	// ------------------------------------------------------------------
	// Configuration registers; writes are always taken.
	// ------------------------------------------------------------------
	logic [31:0] ref_clock_q;
	logic [3:0]  spread_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_clock_q <= pssu_pkg::REF_CLOCK_RST;
			spread_q    <= pssu_pkg::SPREAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pssu_pkg::CFG_REF_CLOCK: ref_clock_q <= cfg_data;
				pssu_pkg::CFG_SPREAD:    spread_q    <= cfg_data[3:0];
				default: ;  // unmapped index: drop the write
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input fields
	// ------------------------------------------------------------------
	logic [9:0]  in_m;
	logic [6:0]  in_n;
	logic [31:0] in_mode;
	logic        s_accept;

	assign in_m     = s_tdata[9:0];
	assign in_n     = s_tdata[16:10];
	assign in_mode  = s_tdata[48:17];
	assign s_accept = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Shared radix-2 restoring divider, one quotient bit per cycle. A load
	// overrides stepping, so the next division can start on the same edge
	// the previous one finishes.
	// A zero divisor yields all ones, which saturates downstream.
	// ------------------------------------------------------------------
	pssu_pkg::pssu_state_t state_q, state_nxt;

	logic [31:0] rem_q, quo_q, dvsr_q;
	logic [4:0]  cnt_q;
	logic        div_run, div_last, div_ld;
	logic [31:0] div_a, div_b;
	logic [32:0] rem_shift, rem_diff;
	logic        rem_ge;
	logic [31:0] rem_nxt, quo_nxt;

	assign div_run   = state_q inside {pssu_pkg::ST_DIV_FREF, pssu_pkg::ST_DIV_FM,
	                                   pssu_pkg::ST_DIV_DIV, pssu_pkg::ST_DIV_PCT,
	                                   pssu_pkg::ST_DIV_STEP};
	assign div_last  = div_run && (cnt_q == 5'(pssu_pkg::DIV_BITS - 1));
	assign rem_shift = {rem_q, quo_q[31]};
	assign rem_diff  = rem_shift - {1'b0, dvsr_q};
	assign rem_ge    = !rem_diff[32];
	assign rem_nxt   = rem_ge ? rem_diff[31:0] : rem_shift[31:0];
	assign quo_nxt   = {quo_q[30:0], rem_ge};

	always_ff @(posedge clk) begin
		if (div_ld) begin
			rem_q  <= '0;
			quo_q  <= div_a;
			dvsr_q <= div_b;
		end else if (div_run) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (div_ld) begin
			cnt_q <= '0;
		end else if (div_run) begin
			cnt_q <= cnt_q + 5'd1;
		end
	end

	// ------------------------------------------------------------------
	// Working registers
	// ------------------------------------------------------------------
	logic [13:0] prod_q;     // M * percent
	logic [31:0] mode_q;
	logic [31:0] fref_q;
	logic [31:0] norm_q;     // divider value being normalized
	logic [2:0]  expo_q;
	logic [19:0] step_q;
	logic        err_q;

	logic        fref_low;
	logic        norm_shift;
	logic [6:0]  mant_clamp;
	logic [13:0] dvsr_norm;
	logic [19:0] step_sat;
	logic        out_load;

	assign fref_low   = quo_nxt < pssu_pkg::MIN_FREF;
	assign norm_shift = (norm_q > pssu_pkg::MANT_MAX) && (expo_q < pssu_pkg::EXP_MAX);
	assign mant_clamp = (norm_q > pssu_pkg::MANT_MAX) ? pssu_pkg::MANT_MAX[6:0] : norm_q[6:0];
	assign dvsr_norm  = {7'd0, mant_clamp} << expo_q;
	assign step_sat   = (quo_nxt > {12'd0, pssu_pkg::STEP_MAX}) ? pssu_pkg::STEP_MAX
	                                                            : quo_nxt[19:0];

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pssu_pkg::ST_IDLE: begin
				if (s_accept) state_nxt = pssu_pkg::ST_DIV_FREF;
			end
			pssu_pkg::ST_DIV_FREF: begin
				if (div_last) state_nxt = fref_low ? pssu_pkg::ST_DONE : pssu_pkg::ST_DIV_FM;
			end
			pssu_pkg::ST_DIV_FM: begin
				if (div_last) state_nxt = pssu_pkg::ST_DIV_DIV;
			end
			pssu_pkg::ST_DIV_DIV: begin
				if (div_last) state_nxt = pssu_pkg::ST_NORM;
			end
			pssu_pkg::ST_NORM: begin
				if (!norm_shift) state_nxt = pssu_pkg::ST_DIV_PCT;
			end
			pssu_pkg::ST_DIV_PCT: begin
				if (div_last) state_nxt = pssu_pkg::ST_DIV_STEP;
			end
			pssu_pkg::ST_DIV_STEP: begin
				if (div_last) state_nxt = pssu_pkg::ST_DONE;
			end
			pssu_pkg::ST_DONE: begin
				if (out_load) state_nxt = pssu_pkg::ST_IDLE;
			end
			default: state_nxt = pssu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pssu_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs (divider operand select and handshakes)
	// ------------------------------------------------------------------
	always_comb begin
		div_ld   = 1'b0;
		div_a    = '0;
		div_b    = '0;
		s_tready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			pssu_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				// fref = ref_clock / (N + 1)
				div_ld   = s_accept;
				div_a    = ref_clock_q;
				div_b    = {24'd0, {1'b0, in_n} + 8'd1};
			end
			pssu_pkg::ST_DIV_FREF: begin
				// fm = fref / 70
				div_ld = div_last && !fref_low;
				div_a  = quo_nxt;
				div_b  = pssu_pkg::MIN_FREF;
			end
			pssu_pkg::ST_DIV_FM: begin
				// div = fref / (4 * fm)
				div_ld = div_last;
				div_a  = fref_q;
				div_b  = {quo_nxt[29:0], 2'b00};
			end
			pssu_pkg::ST_NORM: begin
				// step = ((M * percent) << 18) / 100
				div_ld = !norm_shift;
				div_a  = {prod_q, {pssu_pkg::STEP_SHIFT{1'b0}}};
				div_b  = pssu_pkg::PCT_SCALE;
			end
			pssu_pkg::ST_DIV_PCT: begin
				// step /= mantissa << exponent
				div_ld = div_last;
				div_a  = quo_nxt;
				div_b  = {18'd0, dvsr_norm};
			end
			pssu_pkg::ST_DONE: begin
				out_load = !m_tvalid || m_tready;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Datapath captures
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			pssu_pkg::ST_IDLE: begin
				if (s_accept) begin
					prod_q <= 14'(in_m * spread_q);
					mode_q <= in_mode;
					err_q  <= 1'b0;
				end
			end
			pssu_pkg::ST_DIV_FREF: begin
				if (div_last) begin
					fref_q <= quo_nxt;
					err_q  <= fref_low;
				end
			end
			pssu_pkg::ST_DIV_DIV: begin
				if (div_last) begin
					norm_q <= quo_nxt;
					expo_q <= '0;
				end
			end
			pssu_pkg::ST_NORM: begin
				// halve while above the mantissa range and the exponent is below 7
				if (norm_shift) begin
					norm_q <= {1'b0, norm_q[31:1]};
					expo_q <= expo_q + 3'd1;
				end
			end
			pssu_pkg::ST_DIV_STEP: begin
				if (div_last) step_q <= step_sat;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Output register; holds the result until the sink takes the beat.
	// ------------------------------------------------------------------
	logic [19:0] out_step_q;
	logic [2:0]  out_expo_q;
	logic [6:0]  out_mant_q;
	logic [31:0] out_mode_q;
	logic        out_err_q;
	logic        m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_err_q <= err_q;
			if (err_q) begin
				// reference too low: zero every field
				out_step_q <= '0;
				out_expo_q <= '0;
				out_mant_q <= '0;
				out_mode_q <= '0;
			end else begin
				out_step_q <= step_q;
				out_expo_q <= expo_q;
				out_mant_q <= mant_clamp;
				out_mode_q <= {mode_q[31:16], pssu_pkg::MODE_FIELD_SET, mode_q[11:0]};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_mode_q, out_mant_q, out_expo_q, out_step_q};
	assign m_tuser  = out_err_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`PSSU_ASSERT_NEXT(a_accept_starts_div, s_accept,
		(state_q == pssu_pkg::ST_DIV_FREF) && (cnt_q == 5'd0),
		"accepted item did not start the reference division")
	`PSSU_ASSERT_NEXT(a_norm_exit_loads, (state_q == pssu_pkg::ST_NORM) && !norm_shift,
		(state_q == pssu_pkg::ST_DIV_PCT) && (cnt_q == 5'd0),
		"normalization exit did not load the percent division")
	`PSSU_ASSERT_SAME(a_err_zero_fields, m_tvalid && m_tuser, m_tdata == 64'd0,
		"error result carries nonzero fields")
	`PSSU_ASSERT_SAME(a_mode_field_set, m_tvalid && !m_tuser,
		m_tdata[45:42] == pssu_pkg::MODE_FIELD_SET,
		"mode word field not set in result")

endmodule
